### src/assert_macros.svh
// Assertion macros used by the RTL of the grouped hash set.
// Depends on nothing; included by modules that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### src/ghs_pkg.sv
// Package for the grouped hash set: sizes, commands and a helper function.
// Depends on nothing.
package ghs_pkg;
    localparam int NUM_GROUPS_DEF  = 1024;
    localparam int GROUP_SLOTS_DEF = 15;
    localparam int KEY_W   = 64;
    localparam int HOPS_W  = 10;
    localparam int CMPS_W  = 14;
    localparam int FULLS_W = 11;

    typedef enum logic {
        t_CMD_FIND   = 1'b0,
        t_CMD_INSERT = 1'b1
    } t_cmd;

    function automatic logic [8:0] reduce_hash(input logic [KEY_W-1:0] k);
        logic [7:0] b;
        b = k[7:0];
        if (b == 8'd0) return 9'd8;
        if (b == 8'd1) return 9'd9;
        return {1'b0, b};
    endfunction
endpackage

### src/ghs_if.sv
// Valid/ready channel interfaces for the grouped hash set.
// Depends on ghs_pkg.
interface ghs_in_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic [ghs_pkg::KEY_W-1:0]  key;
    modport source (output valid, cmd, key, input ready);
    modport sink   (input valid, cmd, key, output ready);
endinterface

interface ghs_out_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic                         inserted;
    logic                         table_full;
    logic [ghs_pkg::HOPS_W-1:0]   hops;
    logic [ghs_pkg::CMPS_W-1:0]   compares;
    logic [ghs_pkg::FULLS_W-1:0]  full_groups;
    modport source (output valid, found, inserted, table_full, hops, compares, full_groups,
                    input ready);
    modport sink   (input valid, found, inserted, table_full, hops, compares, full_groups,
                    output ready);
endinterface

### src/grouped_hash_set_overflow_bits_unit.sv
// Grouped hash-key set with per-group overflow bits (top level).
// Channels: in (cmd, key) and out (found, inserted, table_full, hops, compares,
// full_groups), valid/ready; a transfer happens when both are high.
// One item is processed at a time. After reset a clearing pass walks all
// NUM_GROUPS groups, one per cycle, writing zero fill and overflow; in.ready
// stays low during it.
// Each probed group takes a memory read, then a compare of all slots at
// once. A find probes the home group and follows set overflow bits to
// further groups; an insert that finds no match then walks the groups again
// from home in the placement walk, setting the overflow bit in each full
// group, and writes the key into the first group with a free slot.
// The result sits in an output register; the next item is taken while it
// waits, and the result of that item is held until the receiver takes the
// pending one. A stalled receiver therefore blocks at most one extra item.
// Keys in slots beyond a group's fill are never compared, so the key store
// needs no clearing.
module grouped_hash_set_overflow_bits_unit #(
    parameter int NUM_GROUPS  = ghs_pkg::NUM_GROUPS_DEF,
    parameter int GROUP_SLOTS = ghs_pkg::GROUP_SLOTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ghs_in_if.sink    i_in,
    ghs_out_if.source o_out
);
`include "assert_macros.svh"
    localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int FW = $clog2(GROUP_SLOTS + 1);
    localparam int VW = $clog2(NUM_GROUPS + 1);
    localparam int SW = $clog2(GROUP_SLOTS + 1);
    localparam int HW = ghs_pkg::HOPS_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_F_RD, S_F_CMP, S_I_RD, S_I_CMP, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic [GW-1:0] r_addr, n_addr, r_home;
    logic [VW-1:0] r_visit, n_visit;
    logic          r_cmd;
    logic [ghs_pkg::KEY_W-1:0] r_key;
    logic [HW-1:0] r_hops, n_hops;
    logic [ghs_pkg::CMPS_W-1:0] r_cmps, n_cmps;
    logic [ghs_pkg::FULLS_W-1:0] r_fulls, n_fulls;
    logic r_found, n_found, r_full, n_full, r_ins, n_ins;

    logic [GROUP_SLOTS-1:0][ghs_pkg::KEY_W-1:0] rd_keys;
    logic [FW-1:0] rd_fill;
    logic [7:0]    rd_ovf;
    logic wr_en, wr_key_en;
    logic [FW-1:0] wr_fill;
    logic [7:0]    wr_ovf;

    logic [7:0] bitm;
    logic hit;
    logic [SW-1:0] cnt;
    logic last_visit;
    logic [GW-1:0] next_addr;

    ghs_group_mem #(.NUM_GROUPS(NUM_GROUPS), .GROUP_SLOTS(GROUP_SLOTS)) u_mem (
        .i_clk(i_clk), .i_rd_addr(r_addr), .o_rd_keys(rd_keys), .o_rd_fill(rd_fill),
        .o_rd_ovf(rd_ovf), .i_wr_en(wr_en), .i_wr_addr(r_addr), .i_wr_key_en(wr_key_en),
        .i_wr_slot(rd_fill), .i_wr_key(r_key), .i_wr_fill(wr_fill), .i_wr_ovf(wr_ovf)
    );

    // Output register
    logic r_ovalid;
    logic r_o_found, r_o_ins, r_o_full;
    logic [HW-1:0] r_o_hops;
    logic [ghs_pkg::CMPS_W-1:0] r_o_cmps;
    logic [ghs_pkg::FULLS_W-1:0] r_o_fulls;

    assign bitm = 8'(1) << r_key[2:0];
    assign last_visit = (r_visit == VW'(NUM_GROUPS - 1));
    assign next_addr = GW'(r_addr + GW'(r_visit + VW'(1)));

    always_comb begin
        hit = 1'b0;
        cnt = '0;
        for (int i = 0; i < GROUP_SLOTS; i++) begin
            if (FW'(i) < rd_fill) begin
                if (rd_keys[i] == r_key) hit = 1'b1;
                if (ghs_pkg::reduce_hash(rd_keys[i]) == ghs_pkg::reduce_hash(r_key))
                    cnt = SW'(cnt + SW'(1));
            end
        end
    end

    // Count matches before the first hit in slot order
    logic [SW-1:0] cnt_pre;
    always_comb begin
        logic stop;
        stop = 1'b0;
        cnt_pre = '0;
        for (int i = 0; i < GROUP_SLOTS; i++) begin
            if (FW'(i) < rd_fill && !stop) begin
                if (rd_keys[i] == r_key) stop = 1'b1;
                else if (ghs_pkg::reduce_hash(rd_keys[i]) == ghs_pkg::reduce_hash(r_key))
                    cnt_pre = SW'(cnt_pre + SW'(1));
            end
        end
    end

    always_comb begin
        n_state = r_state; n_addr = r_addr; n_visit = r_visit;
        n_hops = r_hops; n_cmps = r_cmps; n_fulls = r_fulls;
        n_found = r_found; n_full = r_full; n_ins = r_ins;
        wr_en = 1'b0; wr_key_en = 1'b0; wr_fill = '0; wr_ovf = '0;
        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                n_addr = GW'(r_addr + GW'(1));
                if (r_addr == GW'(NUM_GROUPS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_addr = (NUM_GROUPS > 1) ? GW'(i_in.key >> (ghs_pkg::KEY_W - GW)) : '0;
                    n_visit = '0; n_hops = '0; n_cmps = '0;
                    n_found = 1'b0; n_full = 1'b0; n_ins = 1'b0;
                    n_state = S_F_RD;
                end
            end
            S_F_RD: n_state = S_F_CMP;
            S_F_CMP: begin
                if (hit) begin
                    n_found = 1'b1;
                    n_cmps = ghs_pkg::CMPS_W'(r_cmps + cnt_pre + 1);
                    n_state = S_DONE;
                end else begin
                    n_cmps = ghs_pkg::CMPS_W'(r_cmps + cnt);
                    if ((rd_ovf & bitm) == 8'd0 || last_visit) begin
                        if (r_cmd == ghs_pkg::t_CMD_INSERT) begin
                            n_addr = r_home; n_visit = '0; n_full = 1'b1;
                            n_state = S_I_RD;
                        end else n_state = S_DONE;
                    end else begin
                        n_hops = HW'(r_hops + HW'(1));
                        n_addr = next_addr;
                        n_visit = VW'(r_visit + VW'(1));
                        n_state = S_F_RD;
                    end
                end
            end
            S_I_RD: n_state = S_I_CMP;
            S_I_CMP: begin
                wr_en = 1'b1;
                if (rd_fill < FW'(GROUP_SLOTS)) begin
                    wr_key_en = 1'b1;
                    wr_fill = FW'(rd_fill + FW'(1));
                    wr_ovf = rd_ovf;
                    if (wr_fill == FW'(GROUP_SLOTS)) n_fulls = ghs_pkg::FULLS_W'(r_fulls + 1);
                    n_ins = 1'b1; n_full = 1'b0;
                    n_state = S_DONE;
                end else begin
                    wr_fill = rd_fill;
                    wr_ovf = rd_ovf | bitm;
                    n_addr = next_addr;
                    n_visit = VW'(r_visit + VW'(1));
                    n_state = last_visit ? S_DONE : S_I_RD;
                end
            end
            S_DONE: if (!r_ovalid || o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign i_in.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_addr <= '0; r_visit <= '0; r_fulls <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_addr <= n_addr; r_visit <= n_visit; r_fulls <= n_fulls;
            if (r_state == S_DONE && (!r_ovalid || o_out.ready)) r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;
        end
        r_hops <= n_hops; r_cmps <= n_cmps;
        r_found <= n_found; r_full <= n_full; r_ins <= n_ins;
        if (r_state == S_IDLE && i_in.valid) begin
            r_cmd <= i_in.cmd; r_key <= i_in.key; r_home <= n_addr;
        end
        if (r_state == S_DONE && (!r_ovalid || o_out.ready)) begin
            r_o_found <= r_found; r_o_ins <= r_ins; r_o_full <= r_full;
            r_o_hops <= r_hops; r_o_cmps <= r_cmps; r_o_fulls <= r_fulls;
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.found = r_o_found;
    assign o_out.inserted = r_o_ins;
    assign o_out.table_full = r_o_full;
    assign o_out.hops = r_o_hops;
    assign o_out.compares = r_o_cmps;
    assign o_out.full_groups = r_o_fulls;

    `ASSERT_IMPL(a_no_ins_and_full, i_clk, i_rst_n, o_out.valid, !(o_out.inserted && o_out.table_full))
    `ASSERT_IMPL(a_find_no_ins, i_clk, i_rst_n, r_state == S_DONE && r_cmd == ghs_pkg::t_CMD_FIND, !r_ins && !r_full)
    `ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in.valid && i_in.ready, r_state == S_F_RD)
endmodule

### src/ghs_group_mem.sv
// Group memory: key slots, fill count and overflow mask per group, registered read.
// Depends on ghs_pkg.
module ghs_group_mem #(
    parameter int NUM_GROUPS  = ghs_pkg::NUM_GROUPS_DEF,
    parameter int GROUP_SLOTS = ghs_pkg::GROUP_SLOTS_DEF,
    localparam int GW = $clog2(NUM_GROUPS),
    localparam int FW = $clog2(GROUP_SLOTS + 1)
) (
    input  logic                                  i_clk,
    input  logic [GW-1:0]                         i_rd_addr,
    output logic [GROUP_SLOTS-1:0][ghs_pkg::KEY_W-1:0] o_rd_keys,
    output logic [FW-1:0]                         o_rd_fill,
    output logic [7:0]                            o_rd_ovf,
    input  logic                                  i_wr_en,
    input  logic [GW-1:0]                         i_wr_addr,
    input  logic                                  i_wr_key_en,
    input  logic [FW-1:0]                         i_wr_slot,
    input  logic [ghs_pkg::KEY_W-1:0]             i_wr_key,
    input  logic [FW-1:0]                         i_wr_fill,
    input  logic [7:0]                            i_wr_ovf
);
    logic [GROUP_SLOTS-1:0][ghs_pkg::KEY_W-1:0] r_keys [NUM_GROUPS];
    logic [FW+7:0]                              r_meta [NUM_GROUPS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_meta[i_wr_addr] <= {i_wr_fill, i_wr_ovf};
        end
        if (i_wr_key_en) begin
            r_keys[i_wr_addr][i_wr_slot] <= i_wr_key;
        end
        o_rd_keys            <= r_keys[i_rd_addr];
        {o_rd_fill, o_rd_ovf} <= r_meta[i_rd_addr];
    end
endmodule
